@@ rtl/core/tqpt_pkg.sv @@
// tqpt_pkg: shared types and constants of the touch event queue and press tracker
// used by tqpt_csr, tqpt_ctrl, tqpt_dp and the top level; depends on nothing
package tqpt_pkg;

   // request opcodes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   // event kinds
   localparam logic [1:0] EV_DOWN   = 2'd0;
   localparam logic [1:0] EV_MOVE   = 2'd1;
   localparam logic [1:0] EV_UP     = 2'd2;
   localparam logic [1:0] EV_CANCEL = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_HOLD   = 3'd0;
   localparam logic [2:0] CSR_STALE  = 3'd1;
   localparam logic [2:0] CSR_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_ROT    = 3'd4;
   localparam logic [2:0] CSR_LOCK   = 3'd5;

   // rotation codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam logic [12:0] FRAME_MAX = 13'd4096;
   localparam logic [16:0] IDLE_MAX  = 17'd131071;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [12:0]        w;
      logic [12:0]        h;
   } event_type;

   typedef struct packed {
      logic [15:0] hold_time_ms;
      logic [15:0] stale_time_ms;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [1:0]  rotation_code;
      logic        geometry_locked;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic push;
      logic scan_step;
      logic evict;
      logic tick;
      logic pop;
      logic apply;
      logic check;
      logic outp;
      logic read_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic coalesce;
      logic full;
      logic empty;
      logic scan_done;
   } status_type;

   // frame size saturation: 0 reads as 1, above 4096 as 4096
   function automatic logic [12:0] sat_size(input logic [12:0] v);
      logic [12:0] r;
      r = v;
      if (v == 13'd0) r = 13'd1;
      else if (v > FRAME_MAX) r = FRAME_MAX;
      return r;
   endfunction

endpackage

@@ rtl/core/tqpt_csr.sv @@
// tqpt_csr: configuration registers of the press tracker
// depends on tqpt_pkg (cfg_type, register indexes)
module tqpt_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_write_data,
   output tqpt_pkg::cfg_type    cfg
);

   tqpt_pkg::cfg_type cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_time_ms    <= 16'd250;
         cfg_ff.stale_time_ms   <= 16'd2000;
         cfg_ff.frame_width     <= 13'd640;
         cfg_ff.frame_height    <= 13'd360;
         cfg_ff.rotation_code   <= 2'd0;
         cfg_ff.geometry_locked <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            tqpt_pkg::CSR_HOLD:   cfg_ff.hold_time_ms    <= csr_write_data;
            tqpt_pkg::CSR_STALE:  cfg_ff.stale_time_ms   <= csr_write_data;
            tqpt_pkg::CSR_WIDTH:  cfg_ff.frame_width     <= csr_write_data[12:0];
            tqpt_pkg::CSR_HEIGHT: cfg_ff.frame_height    <= csr_write_data[12:0];
            tqpt_pkg::CSR_ROT:    cfg_ff.rotation_code   <= csr_write_data[1:0];
            tqpt_pkg::CSR_LOCK:   cfg_ff.geometry_locked <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/tqpt_ctrl.sv @@
// tqpt_ctrl: sequencer of the press tracker, one request at a time
// depends on tqpt_pkg (cmd_type, status_type, opcodes)
module tqpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_opcode,
   input  tqpt_pkg::status_type    status,
   output tqpt_pkg::cmd_type       cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PUSH  = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_EVICT = 4'd3;
   localparam logic [3:0] ST_TICK  = 4'd4;
   localparam logic [3:0] ST_POP   = 4'd5;
   localparam logic [3:0] ST_APPLY = 4'd6;
   localparam logic [3:0] ST_CHECK = 4'd7;
   localparam logic [3:0] ST_OUTP  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_opcode;
               case (req_opcode)
                  tqpt_pkg::OP_PUSH: state_in = ST_PUSH;
                  tqpt_pkg::OP_TICK: state_in = ST_TICK;
                  default:           state_in = ST_POP;
               endcase
            end
         end
         ST_PUSH: begin
            if (status.full && !status.coalesce) begin
               state_in = ST_SCAN;
            end else begin
               cmd.push = 1'b1;
               state_in = ST_OUTP;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_EVICT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_OUTP;
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = ST_OUTP;
         end
         ST_POP: begin
            if (status.empty) begin
               state_in = ST_CHECK;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            // a query drains the whole queue
            state_in  = (op_ff == tqpt_pkg::OP_QUERY) ? ST_POP : ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_OUTP;
         end
         ST_OUTP: begin
            cmd.outp     = 1'b1;
            cmd.read_out = (op_ff == tqpt_pkg::OP_READ);
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= tqpt_pkg::OP_PUSH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= (state_ff == ST_OUTP);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/tqpt_dp.sv @@
// tqpt_dp: event queue, press state, timers and point rotation
// depends on tqpt_pkg (event_type, cfg_type, cmd_type, status_type)
module tqpt_dp #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tqpt_pkg::cmd_type       cmd,
   input  tqpt_pkg::cfg_type       cfg,
   input  logic [1:0]              req_event_kind,
   input  logic signed [15:0]      req_pos_x,
   input  logic signed [15:0]      req_pos_y,
   input  logic [12:0]             req_size_w,
   input  logic [12:0]             req_size_h,
   output tqpt_pkg::status_type    status,
   output logic                    rsp_is_down,
   output logic                    rsp_point_valid,
   output logic [11:0]             rsp_out_x,
   output logic [11:0]             rsp_out_y,
   output logic [4:0]              rsp_queue_fill
);

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   tqpt_pkg::event_type store_ff [QUEUE_DEPTH];
   logic                mv_ff    [QUEUE_DEPTH];
   tqpt_pkg::event_type ev_ff;
   tqpt_pkg::event_type head_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [IDX_W-1:0]    scan_ff;
   logic                down_ff, rel_ff, havept_ff;
   logic [11:0]         cur_x_ff, cur_y_ff;
   logic [16:0]         idle_ff;
   logic [12:0]         lw_ff, lh_ff;
   logic                is_down_ff, pvalid_ff;
   logic [11:0]         out_x_ff, out_y_ff;
   logic [4:0]          qfill_ff;

   logic [IDX_W-1:0]    tail_idx, app_idx, evict_pos;
   logic [FILL_W-1:0]   fill_m1;
   logic                full, scan_hit, scan_last;
   logic [12:0]         eff_w, eff_h;
   logic [11:0]         wm1, hm1;
   logic [15:0]         hold;
   logic [11:0]         rot_x, rot_y;
   logic [FILL_W+4:0]   fill_ext;

   function automatic logic [11:0] clamp_pt(input logic signed [15:0] v,
                                            input logic [11:0] hi);
      logic [11:0] r;
      r = v[11:0];
      if (v < 16'sd0) r = 12'd0;
      else if (v[14:0] > {3'b000, hi}) r = hi;
      return r;
   endfunction

   // hi - c floored at zero
   function automatic logic [11:0] flip(input logic [11:0] hi, input logic [11:0] c);
      return (c > hi) ? 12'd0 : 12'(hi - c);
   endfunction

   function automatic logic [11:0] min12(input logic [11:0] a, input logic [11:0] b);
      return (a > b) ? b : a;
   endfunction

   // queue status
   assign fill_m1   = fill_ff - FILL_W'(1);
   assign tail_idx  = fill_m1[IDX_W-1:0];
   assign app_idx   = fill_ff[IDX_W-1:0];
   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign scan_hit  = mv_ff[scan_ff];
   assign scan_last = (scan_ff == IDX_W'(QUEUE_DEPTH - 1));
   assign evict_pos = scan_hit ? scan_ff : '0;

   assign status.coalesce  = (ev_ff.kind == tqpt_pkg::EV_MOVE) && (fill_ff != '0)
                             && mv_ff[tail_idx];
   assign status.full      = full;
   assign status.empty     = (fill_ff == '0);
   assign status.scan_done = scan_hit || scan_last;

   // frame in use
   always_comb begin
      if (!cfg.geometry_locked && lw_ff != 13'd0 && lh_ff != 13'd0) begin
         eff_w = lw_ff;
         eff_h = lh_ff;
      end else begin
         eff_w = tqpt_pkg::sat_size(cfg.frame_width);
         eff_h = tqpt_pkg::sat_size(cfg.frame_height);
      end
   end
   assign wm1  = 12'(eff_w - 13'd1);
   assign hm1  = 12'(eff_h - 13'd1);
   assign hold = (cfg.hold_time_ms == 16'd0) ? 16'd1 : cfg.hold_time_ms;

   // rotated point
   always_comb begin
      case (cfg.rotation_code)
         tqpt_pkg::ROT_90: begin
            rot_x = min12(cur_y_ff, hm1);
            rot_y = flip(wm1, cur_x_ff);
         end
         tqpt_pkg::ROT_180: begin
            rot_x = flip(wm1, cur_x_ff);
            rot_y = flip(hm1, cur_y_ff);
         end
         tqpt_pkg::ROT_270: begin
            rot_x = flip(hm1, cur_y_ff);
            rot_y = min12(cur_x_ff, wm1);
         end
         default: begin
            rot_x = cur_x_ff;
            rot_y = cur_y_ff;
         end
      endcase
   end

   // request capture and queue storage: coalesce, append, evict and pop shift
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ev_ff.kind <= req_event_kind;
         ev_ff.x    <= req_pos_x;
         ev_ff.y    <= req_pos_y;
         ev_ff.w    <= req_size_w;
         ev_ff.h    <= req_size_h;
      end
      if (cmd.push && status.coalesce) begin
         store_ff[tail_idx] <= ev_ff;
         mv_ff[tail_idx]    <= 1'b1;
      end else if (cmd.push) begin
         store_ff[app_idx] <= ev_ff;
         mv_ff[app_idx]    <= (ev_ff.kind == tqpt_pkg::EV_MOVE);
      end else if (cmd.evict) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (i >= int'(evict_pos)) begin
               store_ff[i] <= store_ff[i+1];
               mv_ff[i]    <= mv_ff[i+1];
            end
         end
         store_ff[QUEUE_DEPTH-1] <= ev_ff;
         mv_ff[QUEUE_DEPTH-1]    <= (ev_ff.kind == tqpt_pkg::EV_MOVE);
      end else if (cmd.pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
            mv_ff[i]    <= mv_ff[i+1];
         end
      end
      if (cmd.pop) begin
         head_ff <= store_ff[0];
      end
      // result fields
      if (cmd.outp) begin
         is_down_ff <= down_ff;
         pvalid_ff  <= cmd.read_out && down_ff && havept_ff;
         out_x_ff   <= (cmd.read_out && down_ff && havept_ff) ? rot_x : 12'd0;
         out_y_ff   <= (cmd.read_out && down_ff && havept_ff) ? rot_y : 12'd0;
         qfill_ff   <= fill_ext[4:0];
      end
   end

   assign fill_ext = {5'b00000, fill_ff};

   // control state: fill, scan, press, timers, learned frame
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         scan_ff   <= '0;
         down_ff   <= 1'b0;
         rel_ff    <= 1'b0;
         havept_ff <= 1'b0;
         cur_x_ff  <= 12'd0;
         cur_y_ff  <= 12'd0;
         idle_ff   <= 17'd0;
         lw_ff     <= 13'd0;
         lh_ff     <= 13'd0;
      end else begin
         if (cmd.load) scan_ff <= '0;
         if (cmd.scan_step) scan_ff <= scan_ff + IDX_W'(1);
         if (cmd.push && !status.coalesce) fill_ff <= fill_ff + FILL_W'(1);
         if (cmd.pop) begin
            fill_ff <= fill_m1;
            if (!cfg.geometry_locked && store_ff[0].w != 13'd0 && store_ff[0].h != 13'd0) begin
               lw_ff <= tqpt_pkg::sat_size(store_ff[0].w);
               lh_ff <= tqpt_pkg::sat_size(store_ff[0].h);
            end
         end
         if (cmd.tick && idle_ff != tqpt_pkg::IDLE_MAX) idle_ff <= idle_ff + 17'd1;
         if (cmd.apply) begin
            cur_x_ff  <= clamp_pt(head_ff.x, wm1);
            cur_y_ff  <= clamp_pt(head_ff.y, hm1);
            havept_ff <= 1'b1;
            idle_ff   <= 17'd0;
            down_ff   <= (head_ff.kind != tqpt_pkg::EV_CANCEL);
            rel_ff    <= (head_ff.kind == tqpt_pkg::EV_UP);
         end
         if (cmd.check) begin
            if (rel_ff && idle_ff >= {1'b0, hold}) begin
               down_ff <= 1'b0;
               rel_ff  <= 1'b0;
            end else if (down_ff && !rel_ff && cfg.stale_time_ms != 16'd0
                         && idle_ff > {1'b0, cfg.stale_time_ms}) begin
               down_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_is_down     = is_down_ff;
   assign rsp_point_valid = pvalid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_queue_fill  = qfill_ff;

endmodule

@@ rtl/core/touch_event_queue_press_tracker.sv @@
// touch_event_queue_press_tracker: top level of the touch press tracker
// depends on tqpt_pkg, tqpt_csr, tqpt_ctrl and tqpt_dp

// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_valid, and it cannot be held off.
// A tick passes TICK then OUTP, a push PUSH then OUTP; on a full queue with no
// coalesce, SCAN first walks to the first queued move (to the last slot when no
// move is queued; the scan walks one slot a cycle), then EVICT drops it, or the
// oldest event if no move is queued, and appends. A read passes POP, APPLY
// unless the queue is empty, CHECK and OUTP; a query applies each queued event
// in turn (pop, then clamp and press update). Busy falls as the result appears.
module touch_event_queue_press_tracker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [1:0]         req_event_kind,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [12:0]        req_size_w,
   input  logic [12:0]        req_size_h,
   output logic               rsp_valid,
   output logic               rsp_is_down,
   output logic               rsp_point_valid,
   output logic [11:0]        rsp_out_x,
   output logic [11:0]        rsp_out_y,
   output logic [4:0]         rsp_queue_fill,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   tqpt_pkg::cfg_type    cfg;
   tqpt_pkg::cmd_type    cmd;
   tqpt_pkg::status_type status;

   // configuration registers
   tqpt_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   // sequencer
   tqpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   // queue and press datapath
   tqpt_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_event_kind  (req_event_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_size_w      (req_size_w),
      .req_size_h      (req_size_h),
      .status          (status),
      .rsp_is_down     (rsp_is_down),
      .rsp_point_valid (rsp_point_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_queue_fill  (rsp_queue_fill)
   );

`ifndef SYNTHESIS
   // a result only appears once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   // a valid point is only reported while pressed
   a_pt_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_point_valid) |-> rsp_is_down) else $error("point without press");

   // every accepted request occupies the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");

   // the datapath never appends to a full queue
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && status.full) |-> status.coalesce) else $error("append to full queue");
`endif

endmodule
